### sv/differential_drive_odometry_top_macros.svh
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared property forms for the checkers of the odometry block.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometry check failed");

// The consequent must hold after the antecedent, later than in DDO_ASSERT_NEXT.
`define DDO_ASSERT_LATER(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("odometry check failed");

`endif

### sv/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Constants, shared types and helper functions of the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	localparam logic [19:0] RADIUS_RST = 20'd60000;
	localparam logic [21:0] BASE_RST   = 22'd350000;
	localparam logic [9:0]  RED_RST    = 10'd100;
	localparam logic [15:0] CPR_RST    = 16'd44;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_BASE   = 2'd1;
	localparam logic [1:0] REG_RED    = 2'd2;
	localparam logic [1:0] REG_CPR    = 2'd3;

	localparam logic signed [35:0] PI_Q28      = 36'sd843314857;
	localparam logic signed [35:0] TWO_PI_Q28  = 36'sd1686629714;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic [31:0] TWO_PI_Q24 = 32'd105414357;
	localparam logic [31:0] KINV_Q24   = 32'd10188012;
	localparam logic [31:0] MEGA       = 32'd1000000;

	typedef struct packed {
		logic        start;
		logic        is_div;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} unit_rsp_t;

	function automatic logic signed [35:0] wrap_q28(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = v + PI_Q28;
		if (r < 0) r = r + TWO_PI_Q28;
		if (r < 0) r = r + TWO_PI_Q28;
		if (r >= TWO_PI_Q28) r = r - TWO_PI_Q28;
		if (r >= TWO_PI_Q28) r = r - TWO_PI_Q28;
		return r - PI_Q28;
	endfunction

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd843314856;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043836;
			5'd3:  v = 30'd133525158;
			5'd4:  v = 30'd67021686;
			5'd5:  v = 30'd33543515;
			5'd6:  v = 30'd16775850;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194282;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048575;
			5'd11: v = 30'd524287;
			5'd12: v = 30'd262143;
			5'd13: v = 30'd131071;
			5'd14: v = 30'd65535;
			5'd15: v = 30'd32767;
			5'd16: v = 30'd16383;
			5'd17: v = 30'd8191;
			5'd18: v = 30'd4095;
			5'd19: v = 30'd2047;
			5'd20: v = 30'd1023;
			5'd21: v = 30'd511;
			5'd22: v = 30'd255;
			5'd23: v = 30'd127;
			5'd24: v = 30'd63;
			5'd25: v = 30'd31;
			5'd26: v = 30'd15;
			5'd27: v = 30'd7;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/ddo_ifs.sv
// ----------------------------------------------------------------------------
// Odometry channels
// Valid/ready channels for encoder count beats and pose beats.
// ----------------------------------------------------------------------------
interface ddo_counts_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_count_delta;
	logic signed [15:0] right_count_delta;
	logic [23:0]        elapsed_us;

	modport source (output valid, left_count_delta, right_count_delta, elapsed_us,
		input ready);
	modport sink (input valid, left_count_delta, right_count_delta, elapsed_us,
		output ready);
endinterface

interface ddo_pose_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] pos_x_um;
	logic signed [47:0] pos_y_um;
	logic signed [30:0] heading_q28;
	logic signed [31:0] linear_velocity_ums;
	logic signed [31:0] angular_velocity_q16;
	logic               moving_and_turning;

	modport source (output valid, pos_x_um, pos_y_um, heading_q28, linear_velocity_ums,
		angular_velocity_q16, moving_and_turning, input ready);
	modport sink (input valid, pos_x_um, pos_y_um, heading_q28, linear_velocity_ums,
		angular_velocity_q16, moving_and_turning, output ready);
endinterface

### sv/ddo_unit.sv
// ----------------------------------------------------------------------------
// Odometry arithmetic unit
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module ddo_unit
	import ddo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	localparam logic [6:0] MUL_STEPS = 7'd32;
	localparam logic [6:0] DIV_STEPS = 7'd64;

	logic        busy_q;
	logic        done_q;
	logic        div_q;
	logic [6:0]  cnt_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [64:0] rem_q;
	logic [64:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q[63:0], a_q[63]};
	assign ge     = rem_sh >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.is_div ? DIV_STEPS : MUL_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= ge ? rem_sh - {1'b0, b_q} : rem_sh;
				a_q   <= {a_q[62:0], ge};
			end else begin
				if (b_q[0]) acc_q <= acc_q + a_q;
				a_q <= {a_q[62:0], 1'b0};
				b_q <= {1'b0, b_q[63:1]};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = div_q ? a_q : acc_q;

endmodule

### sv/differential_drive_odometry_top.sv
// An accepted count beat yields one pose beat after eight multiplies and five
// divides on the one shared shift-add/shift-subtract unit, then one CORDIC
// iteration per cycle, with sequencing states around them. The input is not
// ready while an item is in work or its pose waits behind an untaken pose beat.
// Configuration writes take effect at once and must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
// Differential-drive odometry
// Wheel travel, heading and pose integration with velocity estimates.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top
	import ddo_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [21:0] cfg_data,
	ddo_counts_if.sink  counts,
	ddo_pose_if.source  pose
);

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ISSUE = 7'b0000010,
		S_WAIT  = 7'b0000100,
		S_HEAD  = 7'b0001000,
		S_CINIT = 7'b0010000,
		S_CORD  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	typedef enum logic [3:0] {
		OP_DPROD, OP_LMUL1, OP_LMUL2, OP_LDIV, OP_RMUL1, OP_RMUL2, OP_RDIV,
		OP_HDIV, OP_XPROD, OP_LPROD, OP_LINDIV, OP_APROD, OP_ANGDIV
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic [19:0] radius_q;
	logic [21:0] base_q;
	logic [9:0]  red_q;
	logic [15:0] cpr_q;

	logic signed [15:0] lc_q;
	logic signed [15:0] rc_q;
	logic [23:0]        el_q;
	logic [25:0]        dd_q;
	logic [63:0]        tmp_q;
	logic signed [39:0] dl_q;
	logic signed [39:0] dr_q;
	logic signed [31:0] dth_q;
	logic signed [31:0] lin_q;
	logic signed [31:0] ang_q;
	logic signed [30:0] head_q;
	logic signed [51:0] x0_q;
	logic signed [51:0] cx_q;
	logic signed [51:0] cy_q;
	logic signed [35:0] cz_q;
	logic [IW-1:0]      i_q;
	logic [47:0]        x_acc_q;
	logic [47:0]        y_acc_q;

	logic               out_valid_q;
	logic signed [30:0] hdg_out_q;
	logic signed [31:0] lin_out_q;
	logic signed [31:0] ang_out_q;
	logic               mt_out_q;

	unit_req_t req;
	unit_rsp_t rsp;

	logic [9:0]         red1;
	logic [15:0]        cpr1;
	logic [21:0]        bw1;
	logic [15:0]        mag_l;
	logic [15:0]        mag_r;
	logic signed [40:0] s_w;
	logic signed [40:0] diff_w;
	logic [40:0]        smag;
	logic [40:0]        dmag;
	logic [31:0]        dthmag;
	logic [63:0]        opa;
	logic [63:0]        opb;
	logic               op_div;
	logic [39:0]        trav_new;
	logic [30:0]        hmag;
	logic [63:0]        ps;
	logic signed [35:0] zw;
	logic signed [35:0] z0;
	logic signed [51:0] xs;
	logic signed [51:0] ys;
	logic signed [35:0] at;
	logic signed [51:0] dx;
	logic signed [51:0] dy;
	logic               load_out;

	function automatic logic signed [31:0] sat_mag(input logic [63:0] q, input logic neg);
		if (neg) begin
			if (q > 64'h8000_0000) return 32'sh8000_0000;
			return $signed(-q[31:0]);
		end
		if (q > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
		return $signed(q[31:0]);
	endfunction

	ddo_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign red1   = (red_q == '0) ? 10'd1 : red_q;
	assign cpr1   = (cpr_q == '0) ? 16'd1 : cpr_q;
	assign bw1    = (base_q == '0) ? 22'd1 : base_q;
	assign mag_l  = lc_q[15] ? 16'(-lc_q) : 16'(lc_q);
	assign mag_r  = rc_q[15] ? 16'(-rc_q) : 16'(rc_q);
	assign s_w    = 41'(dl_q) + 41'(dr_q);
	assign diff_w = 41'(dr_q) - 41'(dl_q);
	assign smag   = s_w[40] ? 41'(-s_w) : 41'(s_w);
	assign dmag   = diff_w[40] ? 41'(-diff_w) : 41'(diff_w);
	assign dthmag = dth_q[31] ? 32'(-dth_q) : 32'(dth_q);

	always_comb begin
		opa    = '0;
		opb    = '0;
		op_div = 1'b0;
		unique case (op_q) inside
			OP_DPROD: begin
				opa = 64'(red1);
				opb = 64'(cpr1);
			end
			OP_LMUL1: begin
				opa = 64'(radius_q);
				opb = 64'(mag_l);
			end
			OP_RMUL1: begin
				opa = 64'(radius_q);
				opb = 64'(mag_r);
			end
			OP_LMUL2, OP_RMUL2: begin
				opa = tmp_q;
				opb = 64'(TWO_PI_Q24);
			end
			OP_LDIV, OP_RDIV: begin
				op_div = 1'b1;
				opa    = tmp_q + (64'(dd_q) << 23);
				opb    = 64'(dd_q) << 24;
			end
			OP_HDIV: begin
				op_div = 1'b1;
				opa    = (64'(dmag) << 28) + 64'(bw1 >> 1);
				opb    = 64'(bw1);
			end
			OP_XPROD: begin
				opa = 64'(smag);
				opb = 64'(KINV_Q24);
			end
			OP_LPROD: begin
				opa = 64'(smag);
				opb = 64'(MEGA);
			end
			OP_LINDIV: begin
				op_div = 1'b1;
				opa    = tmp_q + 64'(el_q);
				opb    = 64'(el_q) << 1;
			end
			OP_APROD: begin
				opa = 64'(dthmag);
				opb = 64'(MEGA);
			end
			OP_ANGDIV: begin
				op_div = 1'b1;
				opa    = tmp_q + (64'(el_q) << 11);
				opb    = 64'(el_q) << 12;
			end
			default: ;
		endcase
	end

	assign req.start  = (state_q == S_ISSUE);
	assign req.is_div = op_div;
	assign req.a      = opa;
	assign req.b      = opb;

	assign trav_new = rsp.res[39:0];
	assign hmag = ((64'(dmag) >= (64'(bw1) << 3)) || (rsp.res > 64'h7FFF_FFFF))
		? 31'h7FFF_FFFF : rsp.res[30:0];
	assign ps = s_w[40] ? -rsp.res : rsp.res;

	assign zw = wrap_q28(36'(dth_q) + 36'(head_q));
	assign z0 = zw <<< 2;

	assign xs = cx_q >>> i_q;
	assign ys = cy_q >>> i_q;
	assign at = $signed({6'd0, atan_q30(5'(i_q))});
	assign dx = (cx_q + 52'sd256) >>> 9;
	assign dy = (cy_q + 52'sd256) >>> 9;

	assign load_out = (state_q == S_DONE) && (!out_valid_q || pose.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			base_q   <= BASE_RST;
			red_q    <= RED_RST;
			cpr_q    <= CPR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[19:0];
				REG_BASE:   base_q   <= cfg_data;
				REG_RED:    red_q    <= cfg_data[9:0];
				REG_CPR:    cpr_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_DPROD;
			head_q      <= '0;
			x_acc_q     <= '0;
			y_acc_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pose.ready && !load_out) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (counts.valid) begin
						op_q    <= OP_DPROD;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (rsp.done) begin
						if (op_q == OP_ANGDIV) begin
							state_q <= S_HEAD;
						end else begin
							op_q    <= op_t'(op_q + 4'd1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_HEAD: begin
					head_q  <= 31'(wrap_q28(36'(head_q) + 36'(dth_q)));
					state_q <= S_CINIT;
				end
				S_CINIT: state_q <= S_CORD;
				S_CORD: begin
					if (i_q == LAST_STEP) state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						if (s_w != '0) begin
							x_acc_q <= x_acc_q + dx[47:0];
							y_acc_q <= y_acc_q + dy[47:0];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && counts.valid) begin
			lc_q <= counts.left_count_delta;
			rc_q <= counts.right_count_delta;
			el_q <= counts.elapsed_us;
		end
		if (state_q == S_WAIT && rsp.done) begin
			case (op_q) inside
				OP_DPROD: dd_q <= rsp.res[25:0];
				OP_LMUL1, OP_LMUL2, OP_RMUL1, OP_RMUL2, OP_LPROD, OP_APROD:
					tmp_q <= rsp.res;
				OP_LDIV: dl_q <= lc_q[15] ? -$signed(trav_new) : $signed(trav_new);
				OP_RDIV: dr_q <= rc_q[15] ? -$signed(trav_new) : $signed(trav_new);
				OP_HDIV: dth_q <= diff_w[40] ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
				OP_XPROD: x0_q <= 52'($signed(ps) >>> 16);
				OP_LINDIV: lin_q <= (el_q == '0) ? 32'sd0 : sat_mag(rsp.res, s_w[40]);
				OP_ANGDIV: ang_q <= (el_q == '0) ? 32'sd0 : sat_mag(rsp.res, dth_q[31]);
				default: ;
			endcase
		end
		if (state_q == S_CINIT) begin
			i_q <= '0;
			if (z0 > HALF_PI_Q30) begin
				cx_q <= '0;
				cy_q <= x0_q;
				cz_q <= z0 - HALF_PI_Q30;
			end else if (z0 < -HALF_PI_Q30) begin
				cx_q <= '0;
				cy_q <= -x0_q;
				cz_q <= z0 + HALF_PI_Q30;
			end else begin
				cx_q <= x0_q;
				cy_q <= '0;
				cz_q <= z0;
			end
		end
		if (state_q == S_CORD) begin
			i_q <= i_q + 1'b1;
			if (cz_q >= 0) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end
		end
		if (load_out) begin
			hdg_out_q <= head_q;
			lin_out_q <= lin_q;
			ang_out_q <= ang_q;
			mt_out_q  <= (s_w != '0) && (dth_q != '0);
		end
	end

	assign counts.ready              = (state_q == S_IDLE);
	assign pose.valid                = out_valid_q;
	assign pose.pos_x_um             = $signed(x_acc_q);
	assign pose.pos_y_um             = $signed(y_acc_q);
	assign pose.heading_q28          = hdg_out_q;
	assign pose.linear_velocity_ums  = lin_out_q;
	assign pose.angular_velocity_q16 = ang_out_q;
	assign pose.moving_and_turning   = mt_out_q;

endmodule

### sv/ddo_checker.sv
// ----------------------------------------------------------------------------
// Odometry checker
// Port-level checks of the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_top_macros.svh"

module ddo_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [47:0] pos_x_um,
	input logic signed [30:0] heading_q28
);

	`DDO_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
	`DDO_ASSERT_LATER(a_busy_two_after, in_valid && in_ready, !in_ready)
	`DDO_ASSERT_NEXT(a_pose_held, out_valid && !out_ready, out_valid)
	`DDO_ASSERT_NEXT(a_pose_stable, out_valid && !out_ready, $stable(pos_x_um) && $stable(heading_q28))

endmodule

bind differential_drive_odometry_top ddo_checker u_ddo_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (counts.valid),
	.in_ready    (counts.ready),
	.out_valid   (pose.valid),
	.out_ready   (pose.ready),
	.pos_x_um    (pose.pos_x_um),
	.heading_q28 (pose.heading_q28)
);

### bench/differential_drive_odometry_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Odometry block testbench
// Encoder count beats are driven through the counts channel under several
// register settings and idling mixes. Every pose beat is compared field by
// field with a pose computed alongside from the same counts and registers, or with zeros for known rows.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top_test;
	import ddo_pkg::*;

	typedef struct {
		logic [47:0] x;
		logic [47:0] y;
		logic [30:0] heading;
		logic [31:0] lin;
		logic [31:0] ang;
		logic        turning;
	} pose_t;

	typedef struct {
		shortint     l;
		shortint     r;
		int unsigned el;
		bit          known;
	} count_row_t;

	localparam longint ANGLE_PI     = 843314857;
	localparam longint ANGLE_TWO_PI = 1686629714;
	localparam longint ANGLE_HALF_PI_Q30 = 1686629713;
	localparam longint GAIN_INV     = 10188012;
	localparam longint unsigned CIRC_Q24 = 105414357;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 800;

	localparam longint ARCTAN[24] = '{843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_RADIUS;
	logic [21:0] cfg_data = '0;

	ddo_counts_if counts_ch();
	ddo_pose_if pose_ch();

	differential_drive_odometry_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .counts(counts_ch.sink), .pose(pose_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	longint unsigned radius_um, base_um, reduction, cpr;
	longint heading_acc;
	logic [47:0] x_acc, y_acc;
	pose_t pending_poses[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int turning_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	function automatic longint wrap_angle(longint v);
		longint r;
		r = (v + ANGLE_PI) % ANGLE_TWO_PI;
		if (r < 0) r += ANGLE_TWO_PI;
		return r - ANGLE_PI;
	endfunction

	function automatic longint wheel_travel(longint c);
		longint unsigned red, rev, mag, num, den, t;
		red = (reduction != 0) ? reduction : 1;
		rev = (cpr != 0) ? cpr : 1;
		mag = (c < 0) ? -c : c;
		num = radius_um * mag * CIRC_Q24;
		den = (red * rev) << 24;
		t = (num + den / 2) / den;
		return (c < 0) ? -longint'(t) : longint'(t);
	endfunction

	function automatic longint round_div(longint n, longint unsigned d);
		longint unsigned mag, q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic pose_t advance_pose(shortint lc, shortint rc, int unsigned el);
		pose_t p;
		longint dl, dr, s, diff, dth, z, x0, x, y, nx, lin, ang;
		longint unsigned bw, mag, q, rem, v;
		bw = (base_um != 0) ? base_um : 1;
		dl = wheel_travel(lc);
		dr = wheel_travel(rc);
		s = dl + dr;
		diff = dr - dl;
		mag = (diff < 0) ? -diff : diff;
		q = mag / bw;
		rem = mag % bw;
		if (q >= 8) begin
			v = 64'd2147483647;
		end else begin
			v = (q << 28) + ((rem << 28) + bw / 2) / bw;
			if (v > 64'd2147483647) v = 64'd2147483647;
		end
		dth = (diff < 0) ? -longint'(v) : longint'(v);
		heading_acc = wrap_angle(heading_acc + dth);
		if (s != 0) begin
			z = wrap_angle(dth + heading_acc) * 4;
			x0 = (s * GAIN_INV) >>> 16;
			x = x0;
			y = 0;
			if (z > ANGLE_HALF_PI_Q30) begin
				x = 0; y = x0; z -= ANGLE_HALF_PI_Q30;
			end else if (z < -ANGLE_HALF_PI_Q30) begin
				x = 0; y = -x0; z += ANGLE_HALF_PI_Q30;
			end
			for (int i = 0; i < 24; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
				end else begin
					nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
				end
				x = nx;
			end
			x_acc = x_acc + 48'((x + 256) >>> 9);
			y_acc = y_acc + 48'((y + 256) >>> 9);
		end
		lin = 0;
		ang = 0;
		if (el != 0) begin
			lin = sat32(round_div(s * 1000000, longint'(el) * 2));
			ang = sat32(round_div(dth * 1000000, longint'(el) * 4096));
		end
		p.x = x_acc;
		p.y = y_acc;
		p.heading = heading_acc[30:0];
		p.lin = lin[31:0];
		p.ang = ang[31:0];
		p.turning = (s != 0 && dth != 0);
		return p;
	endfunction

	task automatic write_reg(logic [1:0] idx, longint unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[21:0];
		case (idx)
			REG_RADIUS: radius_um = val & 64'hFFFFF;
			REG_BASE:   base_um = val & 64'h3FFFFF;
			REG_RED:    reduction = val & 64'h3FF;
			default:    cpr = val & 64'hFFFF;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_counts(shortint lc, shortint rc, int unsigned el, bit known);
		pose_t p;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			counts_ch.valid <= 1'b0;
			@(negedge clk);
		end
		counts_ch.valid <= 1'b1;
		counts_ch.left_count_delta <= lc;
		counts_ch.right_count_delta <= rc;
		counts_ch.elapsed_us <= el[23:0];
		do @(posedge clk); while (!counts_ch.ready);
		p = advance_pose(lc, rc, el);
		if (known) p = '{default: '0};
		pending_poses.push_back(p);
		beats_in++;
	endtask

	task automatic random_counts(int n);
		shortint lc, rc;
		int unsigned el;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(5))
				0: begin lc = $urandom; rc = $urandom; end
				1: begin lc = $urandom_range(400) - 200; rc = lc; end
				2: begin lc = $urandom_range(400) - 200; rc = -lc; end
				3: begin lc = 0; rc = 0; end
				default: begin
					lc = $urandom_range(2000) - 1000;
					rc = lc + $urandom_range(200) - 100;
				end
			endcase
			case ($urandom_range(3))
				0: el = 0;
				1: el = $urandom & 24'hFFFFFF;
				default: el = $urandom_range(100000, 1000);
			endcase
			if (k == n / 2) begin
				@(negedge clk);
				counts_ch.valid <= 1'b0;
				while (pending_poses.size() != 0) @(posedge clk);
			end
			send_counts(lc, rc, el, 1'b0);
		end
		@(negedge clk);
		counts_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		pose_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		pose_t want;
		if (arst_n) begin
			if ((counts_ch.valid && counts_ch.ready) || (pose_ch.valid && pose_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (pose_ch.valid && pose_ch.ready) begin
				beats_out++;
				if (pose_ch.moving_and_turning) turning_seen++;
				if (pending_poses.size() == 0) begin
					errors++;
					$display("%0t: pose beat with nothing expected", $time);
				end else begin
					want = pending_poses.pop_front();
					if (pose_ch.pos_x_um !== want.x) begin
						errors++;
						$display("%0t: x exp %h got %h", $time, want.x, pose_ch.pos_x_um);
					end
					if (pose_ch.pos_y_um !== want.y) begin
						errors++;
						$display("%0t: y exp %h got %h", $time, want.y, pose_ch.pos_y_um);
					end
					if (pose_ch.heading_q28 !== want.heading) begin
						errors++;
						$display("%0t: heading exp %h got %h", $time, want.heading,
							pose_ch.heading_q28);
					end
					if (pose_ch.linear_velocity_ums !== want.lin) begin
						errors++;
						$display("%0t: linear vel exp %h got %h", $time, want.lin,
							pose_ch.linear_velocity_ums);
					end
					if (pose_ch.angular_velocity_q16 !== want.ang) begin
						errors++;
						$display("%0t: angular vel exp %h got %h", $time, want.ang,
							pose_ch.angular_velocity_q16);
					end
					if (pose_ch.moving_and_turning !== want.turning) begin
						errors++;
						$display("%0t: turning exp %b got %b", $time, want.turning,
							pose_ch.moving_and_turning);
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("differential_drive_odometry_top_test: FAIL");
				$finish;
			end
		end
	end

	count_row_t rows[] = '{
		'{0, 0, 0, 1}, '{0, 0, 5000, 1},
		'{32767, 32767, 1, 0}, '{-32768, -32768, 16777215, 0},
		'{32767, -32768, 1000, 0}, '{-32768, 32767, 0, 0},
		'{1, 0, 20000, 0}, '{0, 1, 20000, 0}, '{-1, 0, 1, 0},
		'{100, -100, 50000, 0}, '{-100, 100, 50000, 0},
		'{500, 500, 100000, 0}, '{3000, 2000, 33333, 0},
		'{-2000, -3000, 16777215, 0}, '{20000, -20000, 7, 0},
		'{0, 0, 1, 0}
	};

	initial begin
		radius_um = RADIUS_RST;
		base_um = BASE_RST;
		reduction = RED_RST;
		cpr = CPR_RST;
		heading_acc = 0;
		x_acc = '0;
		y_acc = '0;
		counts_ch.valid = 1'b0;
		counts_ch.left_count_delta = '0;
		counts_ch.right_count_delta = '0;
		counts_ch.elapsed_us = '0;
		pose_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) send_counts(rows[i].l, rows[i].r, rows[i].el, rows[i].known);
		@(negedge clk);
		counts_ch.valid <= 1'b0;
		random_counts(40);

		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					write_reg(REG_RADIUS, 1000000); write_reg(REG_BASE, 4000000);
					write_reg(REG_RED, 1000); write_reg(REG_CPR, 65535);
					send_idle_pct = 0; recv_stall_pct = 0;
				end
				1: begin
					write_reg(REG_RADIUS, 1); write_reg(REG_BASE, 0);
					write_reg(REG_RED, 0); write_reg(REG_CPR, 0);
					send_idle_pct = 61; recv_stall_pct = 0;
				end
				2: begin
					write_reg(REG_RADIUS, 1000000); write_reg(REG_BASE, 1);
					write_reg(REG_RED, 1); write_reg(REG_CPR, 1);
					send_idle_pct = 0; recv_stall_pct = 61;
				end
				default: begin
					write_reg(REG_RADIUS, $urandom_range(200000, 10000));
					write_reg(REG_BASE, $urandom_range(800000, 100000));
					write_reg(REG_RED, $urandom_range(200, 1));
					write_reg(REG_CPR, $urandom_range(4096, 16));
					send_idle_pct = 21; recv_stall_pct = 21;
				end
			endcase
			random_counts(140);
		end

		while (pending_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d count beats and checked %0d pose beats (%0d turning).",
			beats_in, beats_out, turning_seen);
		$display("Five register settings, including extremes, under four idling mixes.");
		if (errors == 0 && pending_poses.size() == 0) begin
			$display("differential_drive_odometry_top_test: PASS");
		end else begin
			$display("differential_drive_odometry_top_test: FAIL");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+sv
sv/ddo_pkg.sv
sv/ddo_ifs.sv
sv/ddo_unit.sv
sv/differential_drive_odometry_top.sv
sv/ddo_checker.sv
bench/differential_drive_odometry_top_test.sv
